/* rtl/spiaf_pkg.sv */
// ----------------------------------------------------------------------------
// spiaf_pkg
// Shared types, register codes and helper functions of the SPI adapter
// register slave with its receive and transmit FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none

package spiaf_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned FIFO_DEPTH   = 256;
  localparam int unsigned PTR_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned IDENT_LENGTH = 8;
  localparam int unsigned IDENT_POS_W  = $clog2(IDENT_LENGTH);
  localparam int unsigned CFG_IDX_W    = 1;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [IDENT_POS_W-1:0] ident_pos_t;

  // What one input word asks of the block.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINK  = 2'd2,
    KIND_CARD  = 2'd3
  } kind_e;

  // Bus register map.
  localparam logic [3:0] REG_LENGTH_UPPER = 4'd2;
  localparam logic [3:0] REG_CARD_PRESENT = 4'd3;
  localparam logic [3:0] REG_RECV_HEAD    = 4'd4;
  localparam logic [3:0] REG_RECV_TAIL    = 4'd5;
  localparam logic [3:0] REG_XMIT_HEAD    = 4'd6;
  localparam logic [3:0] REG_XMIT_TAIL    = 4'd7;
  localparam logic [3:0] REG_DISCARD      = 4'd8;
  localparam logic [3:0] REG_FEED         = 4'd9;
  localparam logic [3:0] REG_CLOCK        = 4'd10;
  localparam logic [3:0] REG_SELECT       = 4'd11;
  localparam logic [3:0] REG_IRQ_FIRED    = 4'd12;
  localparam logic [3:0] REG_IRQ_ARMED    = 4'd13;
  localparam logic [3:0] REG_DATA_PORT    = 4'd14;
  localparam logic [3:0] REG_ID_SEQ       = 4'd15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_PATCH = 1'd1;

  localparam byte_t CLOCK_RESET    = 8'd40;
  localparam byte_t IDLE_BYTE      = 8'hff;
  localparam byte_t IRQ_CARD_EVENT = 8'h01;
  localparam byte_t VERSION_MAJOR  = 8'd1;

  function automatic ptr_t ptr_next(ptr_t p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  function automatic ident_pos_t ident_next(ident_pos_t p);
    if (p == IDENT_POS_W'(IDENT_LENGTH - 1)) begin
      return '0;
    end
    return p + ident_pos_t'(1);
  endfunction

  function automatic byte_t ident_byte(ident_pos_t pos, byte_t minor, byte_t patch);
    byte_t b;
    unique case (pos)
      3'd0:    b = IDLE_BYTE;
      3'd1:    b = 8'h73;
      3'd2:    b = 8'h70;
      3'd3:    b = 8'h64;
      3'd4:    b = 8'h72;
      3'd5:    b = VERSION_MAJOR;
      3'd6:    b = minor;
      default: b = patch;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/spi_adapter_fifo_registers.sv */
// A word is taken in IDLE and its result is loaded into the output register as
// the word commits in EXEC. No new word is taken until the last has committed, as
// the FIFO memories are read, then written back; a stalled result holds the block in EXEC.
// Configuration writes are taken in any cycle.
// Reset: rst_ni clears pointers, counts and control registers at once; the
// FIFO memories are not cleared, and no clearing pass follows reset.
// ----------------------------------------------------------------------------
// spi_adapter_fifo_registers
// Sixteen-register byte slave of an SPI adapter with receive and transmit
// FIFOs held in synchronous RAMs, serving bus reads, bus writes, link byte
// slots and card-detect updates.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_adapter_fifo_registers (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input word channel.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [3:0]                     reg_index_i,
  input  wire logic [7:0]                     write_data_i,
  input  wire logic [7:0]                     miso_byte_i,
  input  wire logic                           card_level_i,
  // Result word channel.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [7:0]                     read_data_o,
  output logic                                link_active_o,
  output logic      [7:0]                     mosi_byte_o,
  output logic                                select_out_o,
  output logic      [7:0]                     clock_setting_o,
  output logic                                irq_out_o,
  // Configuration write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [spiaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);

  // The sequencer has two steps: in IDLE a word is taken and the head entry of
  // each FIFO is read; in EXEC the read data is used, the word's effects are
  // written back and the result is loaded into the output register.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;

  logic in_accept;
  logic commit;

  // Captured input word.
  logic [1:0]       kind_q;
  logic [3:0]       reg_q;
  spiaf_pkg::byte_t wdata_q;
  spiaf_pkg::byte_t miso_q;
  logic             level_q;

  // Architectural registers.
  spiaf_pkg::ptr_t       rx_head_q, rx_head_d;
  spiaf_pkg::ptr_t       rx_tail_q, rx_tail_d;
  spiaf_pkg::ptr_t       tx_head_q, tx_head_d;
  spiaf_pkg::ptr_t       tx_tail_q, tx_tail_d;
  spiaf_pkg::len_t       feed_q, feed_d;
  spiaf_pkg::len_t       discard_q, discard_d;
  spiaf_pkg::byte_t      len_upper_q, len_upper_d;
  spiaf_pkg::byte_t      clock_q, clock_d;
  logic                  select_q, select_d;
  spiaf_pkg::byte_t      fired_q, fired_d;
  spiaf_pkg::byte_t      armed_q, armed_d;
  logic                  card_q, card_d;
  spiaf_pkg::ident_pos_t ident_q, ident_d;

  spiaf_pkg::byte_t version_minor_q;
  spiaf_pkg::byte_t version_patch_q;

  // Memory ports.
  logic             rx_we, tx_we;
  spiaf_pkg::byte_t rx_wdata;
  spiaf_pkg::byte_t rx_rdata, tx_rdata;

  // Result of the word in EXEC.
  spiaf_pkg::byte_t res_read;
  spiaf_pkg::byte_t res_mosi;
  logic             res_active;

  logic rx_empty, rx_full, tx_empty, tx_full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The word completes once the output register is free or being emptied.
  assign commit     = (state_q == ST_EXEC) && (!out_valid_o || !out_stall_i);

  assign rx_empty = (rx_head_q == rx_tail_q);
  assign tx_empty = (tx_head_q == tx_tail_q);
  assign rx_full  = (spiaf_pkg::ptr_next(rx_tail_q) == rx_head_q);
  assign tx_full  = (spiaf_pkg::ptr_next(tx_tail_q) == tx_head_q);

  // Both head entries are read when the word is taken; the pointers do not
  // move until the word commits, so the data stays valid throughout EXEC.
  spiaf_ram #(
    .DEPTH (spiaf_pkg::FIFO_DEPTH),
    .WIDTH (spiaf_pkg::BYTE_W)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_tail_q),
    .wdata_i (rx_wdata),
    .re_i    (in_accept),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  spiaf_ram #(
    .DEPTH (spiaf_pkg::FIFO_DEPTH),
    .WIDTH (spiaf_pkg::BYTE_W)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_tail_q),
    .wdata_i (wdata_q),
    .re_i    (in_accept),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      reg_q   <= reg_index_i;
      wdata_q <= write_data_i;
      miso_q  <= miso_byte_i;
      level_q <= card_level_i;
    end
  end

  // Effect of the captured word on every register, worked out as if it
  // commits in this cycle; the memory write enables are gated by commit.
  always_comb begin
    logic rx_push;
    logic tx_push;

    rx_head_d   = rx_head_q;
    rx_tail_d   = rx_tail_q;
    tx_head_d   = tx_head_q;
    tx_tail_d   = tx_tail_q;
    feed_d      = feed_q;
    discard_d   = discard_q;
    len_upper_d = len_upper_q;
    clock_d     = clock_q;
    select_d    = select_q;
    fired_d     = fired_q;
    armed_d     = armed_q;
    card_d      = card_q;
    ident_d     = ident_q;
    res_read    = '0;
    res_mosi    = spiaf_pkg::IDLE_BYTE;
    res_active  = 1'b0;
    rx_push     = 1'b0;
    tx_push     = 1'b0;

    unique case (spiaf_pkg::kind_e'(kind_q))
      spiaf_pkg::KIND_READ: begin
        unique case (reg_q)
          spiaf_pkg::REG_CARD_PRESENT: res_read = spiaf_pkg::BYTE_W'(card_q);
          spiaf_pkg::REG_RECV_HEAD:    res_read = spiaf_pkg::BYTE_W'(rx_head_q);
          spiaf_pkg::REG_RECV_TAIL:    res_read = spiaf_pkg::BYTE_W'(rx_tail_q);
          spiaf_pkg::REG_XMIT_HEAD:    res_read = spiaf_pkg::BYTE_W'(tx_head_q);
          spiaf_pkg::REG_XMIT_TAIL:    res_read = spiaf_pkg::BYTE_W'(tx_tail_q);
          spiaf_pkg::REG_IRQ_FIRED:    res_read = fired_q;
          spiaf_pkg::REG_DATA_PORT: begin
            if (!rx_empty) begin
              res_read  = rx_rdata;
              rx_head_d = spiaf_pkg::ptr_next(rx_head_q);
            end
          end
          spiaf_pkg::REG_ID_SEQ: begin
            res_read = spiaf_pkg::ident_byte(ident_q, version_minor_q, version_patch_q);
            ident_d  = spiaf_pkg::ident_next(ident_q);
          end
          default: res_read = '0;
        endcase
      end
      spiaf_pkg::KIND_WRITE: begin
        unique case (reg_q)
          spiaf_pkg::REG_LENGTH_UPPER: len_upper_d = wdata_q;
          spiaf_pkg::REG_DISCARD:      discard_d   = {len_upper_q, wdata_q};
          spiaf_pkg::REG_FEED:         feed_d      = {len_upper_q, wdata_q};
          spiaf_pkg::REG_CLOCK:        clock_d     = wdata_q;
          spiaf_pkg::REG_SELECT:       select_d    = wdata_q[0];
          spiaf_pkg::REG_IRQ_FIRED:    fired_d     = wdata_q;
          spiaf_pkg::REG_IRQ_ARMED:    armed_d     = wdata_q;
          spiaf_pkg::REG_DATA_PORT: begin
            if (!tx_full) begin
              tx_push   = 1'b1;
              tx_tail_d = spiaf_pkg::ptr_next(tx_tail_q);
            end
          end
          default: ;
        endcase
      end
      spiaf_pkg::KIND_LINK: begin
        if (!tx_empty) begin
          res_mosi   = tx_rdata;
          res_active = 1'b1;
          tx_head_d  = spiaf_pkg::ptr_next(tx_head_q);
          if (discard_q != '0) begin
            discard_d = discard_q - spiaf_pkg::len_t'(1);
          end else begin
            rx_push = 1'b1;
          end
        end else if (feed_q != '0) begin
          res_active = 1'b1;
          feed_d     = feed_q - spiaf_pkg::len_t'(1);
          rx_push    = 1'b1;
        end
      end
      spiaf_pkg::KIND_CARD: begin
        // One-shot interrupt on a change of the card-detect level.
        if ((level_q != card_q) && ((armed_q & spiaf_pkg::IRQ_CARD_EVENT) != '0)) begin
          fired_d = fired_q | spiaf_pkg::IRQ_CARD_EVENT;
          armed_d = armed_q & ~spiaf_pkg::IRQ_CARD_EVENT;
        end
        card_d = level_q;
      end
      default: ;
    endcase

    // A returned byte is dropped when the receive FIFO is full.
    if (rx_push && !rx_full) begin
      rx_tail_d = spiaf_pkg::ptr_next(rx_tail_q);
    end else begin
      rx_push = 1'b0;
    end

    rx_we    = commit && rx_push;
    tx_we    = commit && tx_push;
    rx_wdata = miso_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      feed_q      <= '0;
      discard_q   <= '0;
      len_upper_q <= '0;
      clock_q     <= spiaf_pkg::CLOCK_RESET;
      select_q    <= 1'b0;
      fired_q     <= '0;
      armed_q     <= '0;
      card_q      <= 1'b0;
      ident_q     <= '0;
    end else if (commit) begin
      rx_head_q   <= rx_head_d;
      rx_tail_q   <= rx_tail_d;
      tx_head_q   <= tx_head_d;
      tx_tail_q   <= tx_tail_d;
      feed_q      <= feed_d;
      discard_q   <= discard_d;
      len_upper_q <= len_upper_d;
      clock_q     <= clock_d;
      select_q    <= select_d;
      fired_q     <= fired_d;
      armed_q     <= armed_d;
      card_q      <= card_d;
      ident_q     <= ident_d;
    end
  end

  // Version bytes of the identification sequence; an index beyond the list
  // cannot be expressed on this port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_minor_q <= '0;
      version_patch_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spiaf_pkg::CFG_VERSION_MINOR: version_minor_q <= cfg_data_i;
        spiaf_pkg::CFG_VERSION_PATCH: version_patch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and output register. The status fields show the values after
  // the word has taken effect. A result leaving in the same cycle as a new
  // one commits simply makes way for it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      out_valid_o     <= 1'b0;
      read_data_o     <= '0;
      link_active_o   <= 1'b0;
      mosi_byte_o     <= '0;
      select_out_o    <= 1'b0;
      clock_setting_o <= '0;
      irq_out_o       <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && !commit) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q         <= ST_IDLE;
            out_valid_o     <= 1'b1;
            read_data_o     <= res_read;
            link_active_o   <= res_active;
            mosi_byte_o     <= res_mosi;
            select_out_o    <= select_d;
            clock_setting_o <= clock_d;
            irq_out_o       <= (fired_d != '0);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new result appears only as the word in EXEC commits.
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EXEC))
    else $error("result presented without a word in EXEC");

  // The receive FIFO is never written when full.
  a_rx_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_we |-> (spiaf_pkg::ptr_next(rx_tail_q) != rx_head_q))
    else $error("receive FIFO written while full");

  // Only a link slot stores into the receive FIFO.
  a_rx_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_we |-> (kind_q == spiaf_pkg::KIND_LINK))
    else $error("receive FIFO written outside a link slot");

  // The receive head moves only on a read of the FIFO register.
  a_rx_pop_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (rx_head_d != rx_head_q)) |->
      ((kind_q == spiaf_pkg::KIND_READ) && (reg_q == spiaf_pkg::REG_DATA_PORT)))
    else $error("receive head moved outside a FIFO read");
`endif

endmodule

`default_nettype wire

/* rtl/spiaf_ram.sv */
// ----------------------------------------------------------------------------
// spiaf_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spiaf_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sim/tb_spi_adapter_fifo_registers.sv */
// ----------------------------------------------------------------------------
// tb_spi_adapter_fifo_registers
// Self-checking bench for the SPI adapter register slave. Words go in over
// the valid/stall channel and a behavioural model of the register file, the
// two byte FIFOs, the feed and discard counts, the interrupt registers and
// the identification sequence predicts each result word. Results are compared
// field by field, in order. A short directed table comes first, then runs of
// well-formed bus and link traffic with random content, under several
// version settings and with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_spi_adapter_fifo_registers;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 8;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned TAIL_CYCLES      = 8;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned DRAIN_LIMIT      = 20000;
  localparam int unsigned RUN_LIMIT_CYCLES = 500000;

  // The bus map leaves the two lowest registers unused.
  localparam logic [3:0] REG_SPARE_0 = 4'd0;
  localparam logic [3:0] REG_SPARE_1 = 4'd1;

  // Number of words sent by the end of each version setting.
  localparam int unsigned PHASE_END [4] = '{60, 850, 880, 910};

  typedef struct packed {
    spiaf_pkg::kind_e kind;
    logic [3:0]       reg_idx;
    spiaf_pkg::byte_t wdata;
    spiaf_pkg::byte_t miso;
    logic             level;
  } word_t;

  typedef struct packed {
    spiaf_pkg::byte_t read_data;
    logic             link_active;
    spiaf_pkg::byte_t mosi;
    logic             select;
    spiaf_pkg::byte_t clock_set;
    logic             irq;
  } result_t;

  typedef struct packed {
    word_t   stim;
    logic    known;
    result_t want;
  } dir_row_t;

  // Directed words. Where the result is obvious it is written out here;
  // the other rows are left to the model.
  localparam dir_row_t DIRECTED_ROWS [25] = '{
    // Reserved register straight after reset.
    '{'{spiaf_pkg::KIND_READ,  REG_SPARE_0, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    // The identification sequence, once round and back to its start.
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'hff, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h73, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h70, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h64, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h72, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h01, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'hff, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_ID_SEQ, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'hff, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    // Pop from the empty receive FIFO, then a slot with nothing to send.
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_DATA_PORT, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    '{'{spiaf_pkg::KIND_LINK,  REG_SPARE_1, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, spiaf_pkg::CLOCK_RESET, 1'b0}},
    // Clock setting and select line at their upper extremes.
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_CLOCK,   8'hff, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b0, 8'hff, 1'b0}},
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_SELECT,  8'hff, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 1'b0, spiaf_pkg::IDLE_BYTE, 1'b1, 8'hff, 1'b0}},
    // Two queued bytes, the first one's reply discarded, the second stored.
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DATA_PORT, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DATA_PORT, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DISCARD, 8'h01, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_LINK,  REG_SPARE_0, 8'h00, 8'hff, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_LINK,  REG_SPARE_0, 8'h00, 8'h5a, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_DATA_PORT, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    // Card insertion with the interrupt armed, then the host clears it.
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_IRQ_ARMED, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_CARD,  REG_SPARE_0, 8'h00, 8'h00, 1'b1}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_READ,  spiaf_pkg::REG_IRQ_FIRED, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_IRQ_FIRED, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{'{spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_CLOCK,   8'h00, 8'h00, 1'b0}, 1'b0, '0}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [1:0]                      kind_i;
  logic [3:0]                      reg_index_i;
  logic [7:0]                      write_data_i;
  logic [7:0]                      miso_byte_i;
  logic                            card_level_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [7:0]                      read_data_o;
  logic                            link_active_o;
  logic [7:0]                      mosi_byte_o;
  logic                            select_out_o;
  logic [7:0]                      clock_setting_o;
  logic                            irq_out_o;
  logic                            cfg_we_i;
  logic [spiaf_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]                      cfg_data_i;

  spi_adapter_fifo_registers dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .reg_index_i     (reg_index_i),
    .write_data_i    (write_data_i),
    .miso_byte_i     (miso_byte_i),
    .card_level_i    (card_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .link_active_o   (link_active_o),
    .mosi_byte_o     (mosi_byte_o),
    .select_out_o    (select_out_o),
    .clock_setting_o (clock_setting_o),
    .irq_out_o       (irq_out_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Model state: our own copy of everything the block keeps.
  spiaf_pkg::byte_t      m_rx_mem [spiaf_pkg::FIFO_DEPTH];
  spiaf_pkg::byte_t      m_tx_mem [spiaf_pkg::FIFO_DEPTH];
  spiaf_pkg::ptr_t       m_rx_head, m_rx_tail, m_tx_head, m_tx_tail;
  spiaf_pkg::len_t       m_feed_left, m_discard_left;
  spiaf_pkg::byte_t      m_len_upper, m_clock, m_irq_fired, m_irq_armed;
  logic                  m_select, m_card;
  spiaf_pkg::ident_pos_t m_ident_pos;
  spiaf_pkg::byte_t      m_ver_minor, m_ver_patch;

  // Result words the block still owes us, oldest first.
  result_t     awaited_results [$];
  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned burst_left  = 0;
  bit          hold_off_req = 1'b0;

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t ns: mismatch on %s, got %02h, expected %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  // A returned byte goes into the receive FIFO unless it is full, in which
  // case it is lost.
  task automatic rx_store(input spiaf_pkg::byte_t b);
    if (spiaf_pkg::ptr_t'(m_rx_tail + 1'b1) != m_rx_head) begin
      m_rx_mem[m_rx_tail] = b;
      m_rx_tail = m_rx_tail + 1'b1;
    end
  endtask

  // Applies one accepted word to the model and works out its result word.
  task automatic predict_result(input word_t w, output result_t r);
    spiaf_pkg::len_t len;
    len = {m_len_upper, w.wdata};
    r = '0;
    r.mosi = spiaf_pkg::IDLE_BYTE;
    case (w.kind)
      spiaf_pkg::KIND_READ: begin
        case (w.reg_idx)
          spiaf_pkg::REG_CARD_PRESENT: r.read_data = {7'd0, m_card};
          spiaf_pkg::REG_RECV_HEAD:    r.read_data = m_rx_head;
          spiaf_pkg::REG_RECV_TAIL:    r.read_data = m_rx_tail;
          spiaf_pkg::REG_XMIT_HEAD:    r.read_data = m_tx_head;
          spiaf_pkg::REG_XMIT_TAIL:    r.read_data = m_tx_tail;
          spiaf_pkg::REG_IRQ_FIRED:    r.read_data = m_irq_fired;
          spiaf_pkg::REG_DATA_PORT: begin
            // An empty receive FIFO reads as zero and stays put.
            if (m_rx_head != m_rx_tail) begin
              r.read_data = m_rx_mem[m_rx_head];
              m_rx_head = m_rx_head + 1'b1;
            end
          end
          spiaf_pkg::REG_ID_SEQ: begin
            case (m_ident_pos)
              3'd0:    r.read_data = 8'hff;
              3'd1:    r.read_data = 8'h73;
              3'd2:    r.read_data = 8'h70;
              3'd3:    r.read_data = 8'h64;
              3'd4:    r.read_data = 8'h72;
              3'd5:    r.read_data = 8'h01;
              3'd6:    r.read_data = m_ver_minor;
              default: r.read_data = m_ver_patch;
            endcase
            m_ident_pos = m_ident_pos + 1'b1;
          end
          default: r.read_data = 8'h00;
        endcase
      end
      spiaf_pkg::KIND_WRITE: begin
        case (w.reg_idx)
          spiaf_pkg::REG_LENGTH_UPPER: m_len_upper = w.wdata;
          spiaf_pkg::REG_DISCARD:      m_discard_left = len;
          spiaf_pkg::REG_FEED:         m_feed_left = len;
          spiaf_pkg::REG_CLOCK:        m_clock = w.wdata;
          spiaf_pkg::REG_SELECT:       m_select = w.wdata[0];
          spiaf_pkg::REG_IRQ_FIRED:    m_irq_fired = w.wdata;
          spiaf_pkg::REG_IRQ_ARMED:    m_irq_armed = w.wdata;
          spiaf_pkg::REG_DATA_PORT: begin
            if (spiaf_pkg::ptr_t'(m_tx_tail + 1'b1) != m_tx_head) begin
              m_tx_mem[m_tx_tail] = w.wdata;
              m_tx_tail = m_tx_tail + 1'b1;
            end
          end
          default: ;
        endcase
      end
      spiaf_pkg::KIND_LINK: begin
        // Queued bytes take priority over feeding.
        if (m_tx_head != m_tx_tail) begin
          r.mosi = m_tx_mem[m_tx_head];
          r.link_active = 1'b1;
          m_tx_head = m_tx_head + 1'b1;
          if (m_discard_left != '0) begin
            m_discard_left = m_discard_left - 1'b1;
          end else begin
            rx_store(w.miso);
          end
        end else if (m_feed_left != '0) begin
          r.link_active = 1'b1;
          m_feed_left = m_feed_left - 1'b1;
          rx_store(w.miso);
        end
      end
      default: begin
        // A card-detect change fires the interrupt once, if armed.
        if (w.level != m_card && (m_irq_armed & spiaf_pkg::IRQ_CARD_EVENT) != '0) begin
          m_irq_fired = m_irq_fired | spiaf_pkg::IRQ_CARD_EVENT;
          m_irq_armed = m_irq_armed & ~spiaf_pkg::IRQ_CARD_EVENT;
        end
        m_card = w.level;
      end
    endcase
    r.select    = m_select;
    r.clock_set = m_clock;
    r.irq       = (m_irq_fired != '0);
  endtask

  function automatic spiaf_pkg::byte_t rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.kind    = spiaf_pkg::kind_e'($urandom_range(0, 3));
    w.reg_idx = 4'($urandom_range(0, 15));
    w.wdata   = rand_byte();
    w.miso    = rand_byte();
    w.level   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offers one word and holds it until the block takes it. The expectation
  // is queued at the accepting edge, before the result can appear.
  // Bursts of back-to-back words alternate with short random gaps.
  task automatic send_word(input word_t w, input logic known, input result_t want);
    result_t r;
    int unsigned gap;
    in_valid_i   <= 1'b1;
    kind_i       <= w.kind;
    reg_index_i  <= w.reg_idx;
    write_data_i <= w.wdata;
    miso_byte_i  <= w.miso;
    card_level_i <= w.level;
    do @(posedge clk_i); while (in_stall_o);
    predict_result(w, r);
    awaited_results.push_back(known ? want : r);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One word of the given kind with random filler in the fields it ignores.
  // The byte argument is the write data, the card's reply or the card level.
  task automatic op(input spiaf_pkg::kind_e k, input logic [3:0] r,
                    input spiaf_pkg::byte_t d);
    word_t w;
    w = rand_word();
    w.kind = k;
    if (k == spiaf_pkg::KIND_READ || k == spiaf_pkg::KIND_WRITE) begin
      w.reg_idx = r;
    end
    case (k)
      spiaf_pkg::KIND_WRITE: w.wdata = d;
      spiaf_pkg::KIND_LINK:  w.miso  = d;
      spiaf_pkg::KIND_CARD:  w.level = d[0];
      default: ;
    endcase
    send_word(w, 1'b0, '0);
  endtask

  // The version bytes may only change while the block has nothing in hand.
  task automatic write_version(input spiaf_pkg::byte_t minor,
                               input spiaf_pkg::byte_t patch);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= spiaf_pkg::CFG_VERSION_MINOR;
    cfg_data_i  <= minor;
    @(posedge clk_i);
    m_ver_minor = minor;
    cfg_index_i <= spiaf_pkg::CFG_VERSION_PATCH;
    cfg_data_i  <= patch;
    @(posedge clk_i);
    m_ver_patch = patch;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One short piece of host traffic, chosen at random.
  task automatic run_sequence();
    int unsigned pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Plain noise: any word at all.
      repeat ($urandom_range(1, 4)) send_word(rand_word(), 1'b0, '0);
    end else if (pick < 55) begin
      // A transfer: queue bytes, set up discard and feed, clock the link and
      // collect the replies, sometimes popping more than arrived.
      if ($urandom_range(0, 3) != 0) begin
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_LENGTH_UPPER, 8'h00);
      end
      n = $urandom_range(0, 8);
      repeat (n) op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DATA_PORT, rand_byte());
      if ($urandom_range(0, 1) != 0) begin
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DISCARD, 8'($urandom_range(0, n)));
      end
      if ($urandom_range(0, 1) != 0) begin
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_FEED, 8'($urandom_range(0, 6)));
      end
      repeat (n + $urandom_range(0, 6)) op(spiaf_pkg::KIND_LINK, REG_SPARE_0, rand_byte());
      repeat ($urandom_range(0, n + 3)) begin
        op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_DATA_PORT, 8'h00);
      end
      if ($urandom_range(0, 2) == 0) begin
        op(spiaf_pkg::KIND_READ,
           4'($urandom_range(spiaf_pkg::REG_RECV_HEAD, spiaf_pkg::REG_XMIT_TAIL)), 8'h00);
      end
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 10)) op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_ID_SEQ, 8'h00);
    end else if (pick < 82) begin
      // Card-detect interrupt: mostly armed, mostly a real change of level.
      op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_IRQ_ARMED,
         ($urandom_range(0, 3) != 0) ? (rand_byte() | spiaf_pkg::IRQ_CARD_EVENT)
                                     : rand_byte());
      op(spiaf_pkg::KIND_CARD, REG_SPARE_0,
         {7'($urandom_range(0, 127)), ($urandom_range(0, 3) != 0) ? ~m_card : m_card});
      op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_IRQ_FIRED, 8'h00);
      op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_CARD_PRESENT, 8'h00);
      if ($urandom_range(0, 1) != 0) begin
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_IRQ_FIRED,
           ($urandom_range(0, 3) == 0) ? rand_byte() : 8'h00);
      end
    end else begin
      // Control registers, and accesses to registers that ignore them.
      op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_CLOCK, rand_byte());
      op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_SELECT, rand_byte());
      if ($urandom_range(0, 4) == 0) begin
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_LENGTH_UPPER, 8'hff);
        op(spiaf_pkg::KIND_WRITE,
           ($urandom_range(0, 1) != 0) ? spiaf_pkg::REG_FEED : spiaf_pkg::REG_DISCARD,
           rand_byte());
      end
      op(spiaf_pkg::KIND_READ, 4'($urandom_range(0, 15)), 8'h00);
      op(spiaf_pkg::KIND_WRITE, 4'($urandom_range(0, 15)), rand_byte());
    end
  endtask

  // Result checker: a word moves when valid is high and stall is low at the
  // edge; both are sampled as they stood just before it.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result word with nothing awaited", read_data_o, 8'h00);
      end else begin
        want = awaited_results.pop_front();
        if (read_data_o !== want.read_data) begin
          flag_mismatch("read_data", read_data_o, want.read_data);
        end
        if (link_active_o !== want.link_active) begin
          flag_mismatch("link_active", {7'd0, link_active_o}, {7'd0, want.link_active});
        end
        if (mosi_byte_o !== want.mosi) begin
          flag_mismatch("mosi_byte", mosi_byte_o, want.mosi);
        end
        if (select_out_o !== want.select) begin
          flag_mismatch("select_out", {7'd0, select_out_o}, {7'd0, want.select});
        end
        if (clock_setting_o !== want.clock_set) begin
          flag_mismatch("clock_setting", clock_setting_o, want.clock_set);
        end
        if (irq_out_o !== want.irq) begin
          flag_mismatch("irq_out", {7'd0, irq_out_o}, {7'd0, want.irq});
        end
      end
    end
  end

  // Receiver: stretches of free flow, light and heavy random stalls and a
  // regular stall pattern. When asked, it holds off for a long stretch so
  // that the block backs up and stalls its input.
  initial begin : receiver_stalls
    int unsigned span, mode, period, tick;
    out_stall_i <= 1'b0;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        span   = $urandom_range(10, 60);
        mode   = $urandom_range(0, 3);
        period = $urandom_range(2, 4);
        repeat (span) begin
          @(posedge clk_i);
          tick++;
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= ($urandom_range(0, 99) < 65);
            default: out_stall_i <= ((tick % period) != 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    in_valid_i   <= 1'b0;
    kind_i       <= spiaf_pkg::KIND_READ;
    reg_index_i  <= REG_SPARE_0;
    write_data_i <= 8'h00;
    miso_byte_i  <= 8'h00;
    card_level_i <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= spiaf_pkg::CFG_VERSION_MINOR;
    cfg_data_i   <= 8'h00;
    rst_ni       <= 1'b0;

    // Model state after reset. The FIFO stores are left alone: only bytes
    // that were pushed are ever popped.
    m_rx_head      = '0;
    m_rx_tail      = '0;
    m_tx_head      = '0;
    m_tx_tail      = '0;
    m_feed_left    = '0;
    m_discard_left = '0;
    m_len_upper    = '0;
    m_clock        = spiaf_pkg::CLOCK_RESET;
    m_select       = 1'b0;
    m_irq_fired    = '0;
    m_irq_armed    = '0;
    m_card         = 1'b0;
    m_ident_pos    = '0;
    m_ver_minor    = '0;
    m_ver_patch    = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_version(8'h00, 8'hff);
        1:       write_version(8'hff, 8'h00);
        default: write_version(rand_byte(), rand_byte());
      endcase

      if (phase == 0) begin
        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
          send_word(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
        end
      end

      if (phase == 1) begin
        // Both FIFOs to full and beyond. The receiver is told to hold off
        // meanwhile, so the block also backs up under a steady offer.
        hold_off_req = 1'b1;
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_LENGTH_UPPER, 8'h00);
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DISCARD, 8'h00);
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_FEED, 8'h00);
        while (m_tx_head != m_tx_tail) op(spiaf_pkg::KIND_LINK, REG_SPARE_0, rand_byte());
        while (m_rx_head != m_rx_tail) begin
          op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_DATA_PORT, 8'h00);
        end
        // The last three pushes find the transmit FIFO full and are dropped.
        repeat (spiaf_pkg::FIFO_DEPTH + 2) begin
          op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_DATA_PORT, rand_byte());
        end
        op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_XMIT_TAIL, 8'h00);
        // Sending them all fills the receive FIFO exactly.
        repeat (spiaf_pkg::FIFO_DEPTH - 1) op(spiaf_pkg::KIND_LINK, REG_SPARE_0, rand_byte());
        // Fed replies now find it full; the fifth slot has nothing to do.
        op(spiaf_pkg::KIND_WRITE, spiaf_pkg::REG_FEED, 8'h04);
        repeat (5) op(spiaf_pkg::KIND_LINK, REG_SPARE_0, rand_byte());
        op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_RECV_TAIL, 8'h00);
        repeat (spiaf_pkg::FIFO_DEPTH + 1) begin
          op(spiaf_pkg::KIND_READ, spiaf_pkg::REG_DATA_PORT, 8'h00);
        end
      end

      while (words_sent < PHASE_END[phase]) run_sequence();
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && awaited_results.size() != 0; i++) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      flag_mismatch("result words never delivered", 8'(awaited_results.size()), 8'h00);
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Safety net in case the block hangs.
  initial begin : run_limit
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
